[rtl/rofb_pkg.sv]
// Package for the restricted occupancy basis filter.
// Field widths, register indexes, shared types and the popcount helpers.
// No dependencies.
package rofb_pkg;

    localparam int MASK_W   = 24;  // occupation bits per spin
    localparam int TOTAL_W  = 6;   // total_particles
    localparam int SITES_W  = 4;   // sites_in_use
    localparam int OCC_W    = 7;   // allowed_occupancy_mask
    localparam int IDX_W    = 32;  // basis_index
    localparam int UPCNT_W  = 5;   // up_count
    localparam int POS_W    = 5;   // bit position inside a mask
    localparam int LOCAL_W  = 3;   // local occupation per site, up to 6
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 7;

    localparam int DEF_ORBITALS   = 3;
    localparam int DEF_MAX_SITES  = 8;
    localparam int DEF_FIFO_DEPTH = 4;

    localparam logic [CFGIDX_W-1:0] REG_TOTAL_PARTICLES = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_SITES_IN_USE    = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_ALLOWED_OCC     = 2'd2;

    localparam logic [TOTAL_W-1:0] RST_TOTAL_PARTICLES = 6'd0;
    localparam logic [SITES_W-1:0] RST_SITES_IN_USE    = 4'd8;
    localparam logic [OCC_W-1:0]   RST_ALLOWED_OCC     = 7'd127;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_particles;
        logic [SITES_W-1:0] sites_in_use;
        logic [OCC_W-1:0]   allowed_occ;
    } rofb_cfg_t;

    // one classified candidate, as queued between front and back
    typedef struct packed {
        logic               ok;
        logic               start;
        logic [UPCNT_W-1:0] up_count;
    } rofb_item_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [UPCNT_W-1:0] pop24(input logic [MASK_W-1:0] v);
        return UPCNT_W'(pop8(v[7:0])) + UPCNT_W'(pop8(v[15:8]))
             + UPCNT_W'(pop8(v[23:16]));
    endfunction

endpackage

[rtl/rofb_front.sv]
// Front end: classifies a candidate pair against the configured constraints.
// Pure logic on the incoming beat; result goes into the queue. Uses rofb_pkg.
module rofb_front
    import rofb_pkg::*;
#(
    parameter int ORBITALS  = DEF_ORBITALS,
    parameter int MAX_SITES = DEF_MAX_SITES
) (
    input  rofb_cfg_t           cfg,
    input  logic [MASK_W-1:0]   up_mask,
    input  logic [MASK_W-1:0]   down_mask,
    input  logic                start_of_run,
    output rofb_item_t          item
);

    logic [SITES_W-1:0] sites_eff;
    logic [POS_W-1:0]   used_w;
    logic [UPCNT_W-1:0] nup;
    logic [UPCNT_W-1:0] ndn;
    logic [TOTAL_W-1:0] nsum;
    logic               range_ok;
    logic               sum_ok;
    logic               site_ok;

    assign sites_eff = (cfg.sites_in_use > SITES_W'(MAX_SITES)) ?
                       SITES_W'(MAX_SITES) : cfg.sites_in_use;
    assign used_w    = POS_W'(ORBITALS) * POS_W'(sites_eff);

    assign nup  = pop24(up_mask);
    assign ndn  = pop24(down_mask);
    assign nsum = TOTAL_W'(nup) + TOTAL_W'(ndn);

    assign sum_ok = (nsum == cfg.total_particles);

    always_comb begin
        range_ok = 1'b1;
        for (int p = 0; p < MASK_W; p++) begin
            if ((POS_W'(p) >= used_w) && (up_mask[p] || down_mask[p])) begin
                range_ok = 1'b0;
            end
        end
    end

    // per-site occupation; bit g*sites+s stays below 24 for the active sites
    always_comb begin
        logic [LOCAL_W-1:0] occ;
        logic [POS_W-1:0]   pos;
        site_ok = 1'b1;
        for (int s = 0; s < MAX_SITES; s++) begin
            occ = '0;
            for (int g = 0; g < ORBITALS; g++) begin
                pos = POS_W'(g) * POS_W'(sites_eff) + POS_W'(s);
                occ = occ + LOCAL_W'(up_mask[pos]) + LOCAL_W'(down_mask[pos]);
            end
            if ((SITES_W'(s) < sites_eff) && !cfg.allowed_occ[occ]) begin
                site_ok = 1'b0;
            end
        end
    end

    assign item.ok       = range_ok && sum_ok && site_ok;
    assign item.start    = start_of_run;
    assign item.up_count = nup;

endmodule

[rtl/rofb_fifo.sv]
// Short queue of classified items between the front end and the back end.
// Register array with head/tail pointers and a fill count. Uses rofb_pkg.
module rofb_fifo
    import rofb_pkg::*;
#(
    parameter int DEPTH = DEF_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  rofb_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output rofb_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rofb_item_t           mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/rofb_back.sv]
// Back end: hands out basis indices from a saturating counter and holds the
// result beat in an output register. Uses rofb_pkg.
module rofb_back
    import rofb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  rofb_item_t         item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_accepted,
    output logic [IDX_W-1:0]   out_index,
    output logic [UPCNT_W-1:0] out_up_count
);

    logic [IDX_W-1:0]   count_reg, count_next;
    logic               valid_reg, valid_next;
    logic               acc_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [UPCNT_W-1:0] upc_reg;
    logic [IDX_W-1:0]   base;
    logic               load;

    // output slot frees when empty or when its beat is taken this cycle
    assign load     = item_valid && (!valid_reg || out_ready);
    assign item_pop = load;
    assign base     = item.start ? '0 : count_reg;

    always_comb begin
        count_next = count_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            count_next = base;
            if (item.ok && (base != '1)) begin
                count_next = base + 1'b1;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg   <= item.ok;
            index_reg <= item.ok ? base : '0;
            upc_reg   <= item.up_count;
        end
    end

    assign out_valid    = valid_reg;
    assign out_accepted = acc_reg;
    assign out_index    = index_reg;
    assign out_up_count = upc_reg;

endmodule

[rtl/restricted_occupancy_basis_filter_top.sv]
// Top level of the restricted occupancy basis filter.
// Holds the configuration registers; ties front end, queue and back end together.
// Uses rofb_pkg, rofb_front, rofb_fifo, rofb_back.
//
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+---------------------------------------
//  s_       | in  | s_tvalid / s_tready  | candidate pair, start flag in tuser
//  m_       | out | m_tvalid / m_tready  | index and up count, accepted in tuser
//  cfg_     | in  | cfg_valid/cfg_ready  | register index and write data
//
//  One candidate per cycle sustained while m_tready is high; each input beat is
//  registered in the queue, then in the output register, before its result beat.
//  The index counter in the back end is the only state carried from item to item.
//  aresetn is synchronous, active low; it empties the queue and output slot and
//  restores the register defaults. A stalled m_ side fills the queue, after
//  which s_tready drops. cfg_ready is always high.
module restricted_occupancy_basis_filter_top
    import rofb_pkg::*;
#(
    parameter int ORBITALS   = DEF_ORBITALS,
    parameter int MAX_SITES  = DEF_MAX_SITES,
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // [23:0] up_mask, [47:24] down_mask
    input  logic [0:0]          s_tuser,   // [0] start_of_run

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [31:0] basis_index, [36:32] up_count, zero pad
    output logic [0:0]          m_tuser,   // [0] accepted

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFGIDX_W-1:0] cfg_index,
    input  logic [CFGDAT_W-1:0] cfg_data
);

    rofb_cfg_t          cfg_reg;
    rofb_item_t         front_item;
    rofb_item_t         head_item;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               out_accepted;
    logic [IDX_W-1:0]   out_index;
    logic [UPCNT_W-1:0] out_up_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.total_particles <= RST_TOTAL_PARTICLES;
            cfg_reg.sites_in_use    <= RST_SITES_IN_USE;
            cfg_reg.allowed_occ     <= RST_ALLOWED_OCC;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TOTAL_PARTICLES: cfg_reg.total_particles <= cfg_data[TOTAL_W-1:0];
                REG_SITES_IN_USE:    cfg_reg.sites_in_use    <= cfg_data[SITES_W-1:0];
                REG_ALLOWED_OCC:     cfg_reg.allowed_occ     <= cfg_data[OCC_W-1:0];
                default: ;
            endcase
        end
    end

    rofb_front #(
        .ORBITALS  (ORBITALS),
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .cfg          (cfg_reg),
        .up_mask      (s_tdata[23:0]),
        .down_mask    (s_tdata[47:24]),
        .start_of_run (s_tuser[0]),
        .item         (front_item)
    );

    assign s_tready = !q_full;

    rofb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    rofb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (q_not_empty),
        .item         (head_item),
        .item_pop     (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_accepted (out_accepted),
        .out_index    (out_index),
        .out_up_count (out_up_count)
    );

    assign m_tdata = {3'b000, out_up_count, out_index};
    assign m_tuser = out_accepted;

`ifndef ASSERT_OFF
    a_reject_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0))
        else $error("rejected beat carries a nonzero basis index");

    a_up_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:32] <= 5'd24))
        else $error("up count above mask width");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("output slot or queue not empty after reset");
`endif

endmodule

[dv/rofb_basis_checker.sv]
// Scoreboard for the restricted occupancy basis filter: watches the config, input and
// result channels, predicts each result beat and compares it field by field.
// Depends on rofb_pkg.
module rofb_basis_checker
    import rofb_pkg::*;
#(
    parameter int ORBITALS  = DEF_ORBITALS,
    parameter int MAX_SITES = DEF_MAX_SITES
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [47:0]         s_tdata,   // [23:0] up_mask, [47:24] down_mask
    input  logic [0:0]          s_tuser,   // [0] start_of_run

    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [39:0]         m_tdata,   // [31:0] basis_index, [36:32] up_count, zero pad
    input  logic [0:0]          m_tuser,   // [0] accepted

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFGIDX_W-1:0] cfg_index,
    input  logic [CFGDAT_W-1:0] cfg_data,

    output int                  mismatches,
    output int                  pending
);

    typedef struct packed {
        logic               accepted;
        logic [IDX_W-1:0]   basis_index;
        logic [UPCNT_W-1:0] up_count;
    } basis_result_t;

    basis_result_t      expected_results[$];
    basis_result_t      want;
    basis_result_t      got;

    logic [TOTAL_W-1:0] want_total;
    logic [SITES_W-1:0] sites_cfg;
    logic [OCC_W-1:0]   occ_allowed;
    logic [IDX_W-1:0]   next_index;   // saturates at all ones; not reachable in a short run
    logic [MASK_W-1:0]  up;
    logic [MASK_W-1:0]  dn;

    function automatic logic pair_fits(input logic [MASK_W-1:0] up_m,
                                       input logic [MASK_W-1:0] dn_m);
        int            sites;
        int            width;
        int            local_occ;
        int            s;
        int            g;
        logic [MASK_W:0] span;
        sites = (sites_cfg > MAX_SITES) ? MAX_SITES : int'(sites_cfg);
        width = ORBITALS * sites;
        span  = {{MASK_W{1'b0}}, 1'b1} << width;
        span  = span - 1'b1;
        if (((up_m | dn_m) & ~span[MASK_W-1:0]) != '0)
            return 1'b0;
        if ($countones(up_m) + $countones(dn_m) != int'(want_total))
            return 1'b0;
        for (s = 0; s < sites; s++) begin
            local_occ = 0;
            for (g = 0; g < ORBITALS; g++) begin
                local_occ += int'(up_m[g * sites + s]) + int'(dn_m[g * sites + s]);
            end
            if (!occ_allowed[local_occ])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, seen, wanted);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            want_total  = RST_TOTAL_PARTICLES;
            sites_cfg   = RST_SITES_IN_USE;
            occ_allowed = RST_ALLOWED_OCC;
            next_index  = '0;
            mismatches  = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TOTAL_PARTICLES: want_total  = cfg_data[TOTAL_W-1:0];
                    REG_SITES_IN_USE:    sites_cfg   = cfg_data[SITES_W-1:0];
                    REG_ALLOWED_OCC:     occ_allowed = cfg_data[OCC_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.accepted    = m_tuser[0];
                got.basis_index = m_tdata[IDX_W-1:0];
                got.up_count    = m_tdata[IDX_W +: UPCNT_W];
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding",
                                    64'(m_tdata), 64'(0));
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
                    if (got.basis_index !== want.basis_index)
                        report_mismatch("basis_index", 64'(got.basis_index),
                                        64'(want.basis_index));
                    if (got.up_count !== want.up_count)
                        report_mismatch("up_count", 64'(got.up_count), 64'(want.up_count));
                    if (m_tdata[39:IDX_W+UPCNT_W] !== '0)
                        report_mismatch("m_tdata pad", 64'(m_tdata[39:IDX_W+UPCNT_W]), 64'(0));
                end
            end

            if (s_tvalid && s_tready) begin
                up = s_tdata[MASK_W-1:0];
                dn = s_tdata[2*MASK_W-1:MASK_W];
                if (s_tuser[0])
                    next_index = '0;
                want.accepted    = pair_fits(up, dn);
                want.up_count    = UPCNT_W'($countones(up));
                want.basis_index = want.accepted ? next_index : '0;
                if (want.accepted && next_index != '1)
                    next_index = next_index + 1'b1;
                expected_results.insert(expected_results.size(), want);
            end
        end
        pending = expected_results.size();
    end

endmodule

[dv/testbench.sv]
// Top of the basis filter testbench: clock, reset, config writes and candidate stimulus.
// Instantiates restricted_occupancy_basis_filter_top and rofb_basis_checker; uses rofb_pkg.
module testbench;
    import rofb_pkg::*;

    localparam int ORB  = DEF_ORBITALS;
    localparam int MAXS = DEF_MAX_SITES;
    localparam logic [CFGIDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [47:0]         s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFGIDX_W-1:0] cfg_index = '0;
    logic [CFGDAT_W-1:0] cfg_data  = '0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [39:0]         m_tdata;
    wire  [0:0]          m_tuser;
    wire                 cfg_ready;
    int                  mismatches;
    int                  pending;

    int                  tx_idle_pct = 36;
    int                  rx_idle_pct = 70;

    // what the block is currently set to, for building well-formed candidates
    logic [TOTAL_W-1:0]  plan_total = RST_TOTAL_PARTICLES;
    int                  plan_sites = RST_SITES_IN_USE;
    logic [OCC_W-1:0]    plan_occ   = RST_ALLOWED_OCC;
    int                  site_load[MAXS];

    restricted_occupancy_basis_filter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rofb_basis_checker basis_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // random allowed occupation per site; returns the particle sum
    function automatic int draw_site_loads(input int sites, input logic [OCC_W-1:0] occ);
        int sum;
        int k;
        sum = 0;
        for (int s = 0; s < sites; s++) begin
            k = 0;
            if (occ != '0) begin
                do k = $urandom_range(2 * ORB); while (!occ[k]);
            end
            site_load[s] = k;
            sum += k;
        end
        return sum;
    endfunction

    // candidate that should pass under the current setting when a matching load draw
    // turns up; otherwise the last draw is used as is
    function automatic logic [47:0] build_pair();
        logic [MASK_W-1:0] up;
        logic [MASK_W-1:0] dn;
        logic [5:0]        used;
        int                placed;
        int                j;
        int                pos;
        up = '0;
        dn = '0;
        for (int tries = 0; tries < 100; tries++) begin
            if (draw_site_loads(plan_sites, plan_occ) == int'(plan_total))
                break;
        end
        for (int s = 0; s < plan_sites; s++) begin
            used   = '0;
            placed = 0;
            while (placed < site_load[s]) begin
                j = $urandom_range(2 * ORB - 1);
                if (!used[j]) begin
                    used[j] = 1'b1;
                    placed++;
                end
            end
            for (j = 0; j < 2 * ORB; j++) begin
                pos = (j % ORB) * plan_sites + s;
                if (used[j] && j < ORB)
                    up[pos] = 1'b1;
                else if (used[j])
                    dn[pos] = 1'b1;
            end
        end
        return {dn, up};
    endfunction

    task automatic send_pair(input logic [MASK_W-1:0] up, input logic [MASK_W-1:0] dn,
                             input logic start);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dn, up};
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random();
        logic [47:0] pair;
        int          r;
        r = $urandom_range(99);
        if (r < 70) begin
            pair = build_pair();
        end else if (r < 85) begin
            pair = {24'($urandom), 24'($urandom)};
        end else begin
            pair = build_pair() ^ (48'd1 << $urandom_range(47));
        end
        send_pair(pair[MASK_W-1:0], pair[2*MASK_W-1:MASK_W], $urandom_range(99) < 4);
    endtask

    // stop sending and wait until every result beat has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFGDAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [CFGDAT_W-1:0] total_d,
                                 input logic [CFGDAT_W-1:0] sites_d,
                                 input logic [CFGDAT_W-1:0] occ_d);
        drain_results();
        write_reg(REG_TOTAL_PARTICLES, total_d);
        write_reg(REG_SITES_IN_USE, sites_d);
        write_reg(REG_ALLOWED_OCC, occ_d);
        cfg_valid  <= 1'b0;
        plan_total = total_d[TOTAL_W-1:0];
        plan_sites = (sites_d[SITES_W-1:0] > MAXS) ? MAXS : int'(sites_d[SITES_W-1:0]);
        plan_occ   = occ_d[OCC_W-1:0];
    endtask

    initial begin
        int               r;
        int               eff_sites;
        logic [3:0]       sites_v;
        logic [OCC_W-1:0] occ_v;
        logic [5:0]       total_v;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: total 0, eight sites, every occupation allowed
        send_pair(24'h000000, 24'h000000, 1'b1);
        send_pair(24'h000000, 24'h000000, 1'b0);
        send_pair(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_pair(24'h000001, 24'h000000, 1'b0);
        send_pair(24'h000000, 24'h000000, 1'b1);

        // full lattice, only occupation six allowed
        drain_results();
        write_reg(REG_SPARE, 7'h2A);
        apply_setting(7'd48, 7'd8, 7'h40);
        send_pair(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_pair(24'hFFFFFF, 24'h7FFFFF, 1'b0);

        // zero sites: only the empty pair passes, no site checked
        apply_setting(7'd0, 7'd0, 7'h00);
        send_pair(24'h000000, 24'h000000, 1'b0);
        send_pair(24'h000000, 24'h000001, 1'b0);

        // site count above the maximum clamps to eight; occupations 0 and 2 only
        apply_setting(7'h42, 7'h7F, 7'b0000101);
        send_pair(24'h000001, 24'h000001, 1'b0);
        send_pair(24'h000001, 24'h000002, 1'b0);
        send_pair(24'h000100, 24'h000001, 1'b0);
        send_pair(24'h800000, 24'h800000, 1'b0);

        // unreachable total, plus a bit past the used width
        apply_setting(7'd63, 7'd4, 7'h7F);
        send_pair(24'h000FFF, 24'h000FFF, 1'b0);
        send_pair(24'h001000, 24'h000000, 1'b0);

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 70 : 0;
            rx_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 36 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                r = $urandom_range(9);
                if (r == 0)
                    sites_v = 4'd0;
                else if (r == 1)
                    sites_v = 4'($urandom_range(15, 9));
                else if (r == 2)
                    sites_v = 4'd8;
                else if (r == 3)
                    sites_v = 4'd1;
                else
                    sites_v = 4'($urandom_range(7, 2));
                r = $urandom_range(9);
                occ_v = (r == 0) ? 7'h00 : (r == 1) ? 7'h7F : 7'($urandom_range(127));
                eff_sites = (sites_v > MAXS) ? MAXS : int'(sites_v);
                r = $urandom_range(9);
                if (r < 7)
                    total_v = 6'(draw_site_loads(eff_sites, occ_v));
                else if (r == 7)
                    total_v = 6'd0;
                else
                    total_v = 6'($urandom_range(63));
                // spare upper data bits ride along and must be dropped
                apply_setting({1'($urandom_range(1)), total_v},
                              {3'($urandom_range(7)), sites_v}, occ_v);
                for (int i = 0; i < 46; i++)
                    send_random();
            end
        end

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
